>>> rtl/rcfd_pkg.sv
// Shared widths, register codes, class codes and types of the RC channel frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 11;
    localparam int CH_W       = 4;
    localparam int CLS_W      = 3;
    localparam int MAP_W      = 16;
    localparam int SW_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Result tdata: channel_index, raw_value, mapped_value, switch_state from bit 0 up
    localparam int OUT_FIELDS_W = CH_W + RAW_W + MAP_W + SW_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_RAW_LSB  = CH_W;
    localparam int OUT_MAP_LSB  = CH_W + RAW_W;
    localparam int OUT_SW_LSB   = CH_W + RAW_W + MAP_W;

    localparam int CHANNEL_COUNT_DEF = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_KIND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_POINT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_HIGH    = 3'd6;

    localparam logic [BYTE_W-1:0] RST_SYNC_ADDRESS = 8'd200;
    localparam logic [BYTE_W-1:0] RST_FRAME_KIND   = 8'd22;
    localparam logic [RAW_W-1:0]  RST_STICK_LOW    = 11'd174;
    localparam logic [RAW_W-1:0]  RST_STICK_HIGH   = 11'd1811;
    localparam logic [RAW_W-1:0]  RST_CENTER_POINT = 11'd992;
    localparam logic [RAW_W-1:0]  RST_KNOB_LOW     = 11'd191;
    localparam logic [RAW_W-1:0]  RST_KNOB_HIGH    = 11'd1792;

    typedef logic [CLS_W-1:0] t_class;

    localparam t_class CLS_PLAIN = 3'd0;
    localparam t_class CLS_STICK = 3'd1;
    localparam t_class CLS_KNOB  = 3'd2;
    localparam t_class CLS_SW3   = 3'd3;
    localparam t_class CLS_SW2   = 3'd4;

    localparam logic [SW_W-1:0] SW_OFF  = 2'd0;
    localparam logic [SW_W-1:0] SW_POS1 = 2'd1;
    localparam logic [SW_W-1:0] SW_POS2 = 2'd2;

    localparam logic [RAW_W-1:0] SW3_POS1_RAW = 11'd997;
    localparam logic [RAW_W-1:0] SW3_POS2_RAW = 11'd1792;
    localparam logic [RAW_W-1:0] SW2_ON_ABOVE = 11'd1000;

    // Full-scale position before the fixed-point shift
    localparam int MAP_SPAN = 100;
    localparam int MAP_MAX  = 32767;
    localparam int MAP_MIN  = -32768;

    typedef struct packed {
        logic              valid;
        logic [CH_W-1:0]   index;
        logic [RAW_W-1:0]  raw;
    } t_chan_evt;

    function automatic t_class class_of(input logic [CH_W-1:0] ch);
        t_class cls;
        unique case (ch)
            4'd0, 4'd1, 4'd2, 4'd3: cls = CLS_STICK;
            4'd10, 4'd11:           cls = CLS_KNOB;
            4'd5, 4'd6, 4'd7, 4'd8: cls = CLS_SW3;
            4'd4, 4'd9:             cls = CLS_SW2;
            default:                cls = CLS_PLAIN;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rc_channel_frame_decoder.sv
// Top level of the RC channel frame decoder: configuration, mapping sequencer, result register.
// A byte that completes a stick or knob channel inside valid limits goes through the multiply,
// divider start, bit-serial divide and output states to the result register; any other
// completed channel goes straight from idle to the output state, then to the result register.
// Throughput: bytes that complete no channel are taken every cycle; tready stays low while a
// channel result is worked out and until the result register is free. Synchronous active-low
// reset restores the default configuration and clears the frame state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rc_channel_frame_decoder #(
    parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF,
    parameter int FRACTION_BITS = rcfd_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [rcfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rcfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [rcfd_pkg::BYTE_W-1:0]      s_axis_tdata,  // byte_value
    input  wire logic                             s_axis_tuser,  // frame_start
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // channel_index, raw_value, mapped_value, switch_state, zero padding
    output logic [rcfd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [rcfd_pkg::CLS_W-1:0]            m_axis_tuser,  // channel_class
    output logic                                  m_axis_tlast   // last_channel
);

    import rcfd_pkg::*;

    localparam int S_W   = FRACTION_BITS + 7;
    localparam int P_W   = S_W + RAW_W;
    localparam int N_W   = P_W + 2;
    localparam int D_W   = RAW_W + 1;
    localparam int RES_W = S_W + 1;
    localparam int SAT_W = (RES_W > MAP_W + 1) ? RES_W : MAP_W + 1;

    localparam int SCALE_INT = MAP_SPAN << FRACTION_BITS;
    localparam logic [S_W-1:0] SCALE = S_W'(SCALE_INT);

    localparam logic signed [MAP_W-1:0] MAP_POS_FULL =
        MAP_W'((SCALE_INT > MAP_MAX) ? MAP_MAX : SCALE_INT);
    localparam logic signed [MAP_W-1:0] MAP_NEG_FULL =
        MAP_W'((SCALE_INT > -MAP_MIN) ? MAP_MIN : -SCALE_INT);
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(MAP_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(MAP_MIN);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // configuration
    logic [BYTE_W-1:0] r_sync_address, r_frame_kind;
    logic [RAW_W-1:0]  r_stick_low, r_stick_high, r_center_point, r_knob_low, r_knob_high;

    // sequencer and working registers
    logic [2:0]               r_state, n_state;
    logic [CH_W-1:0]          r_ch, n_ch;
    logic [RAW_W-1:0]         r_raw, n_raw;
    t_class                   r_cls, n_cls;
    logic [SW_W-1:0]          r_sw, n_sw;
    logic signed [MAP_W-1:0]  r_map, n_map;
    logic                     r_lower, n_lower;
    logic [RAW_W-1:0]         r_diff, n_diff;
    logic [RAW_W-1:0]         r_den, n_den;
    logic [P_W-1:0]           r_prod, n_prod;

    // result register
    logic                     r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0]   r_m_data, n_m_data;
    t_class                   r_m_cls, n_m_cls;
    logic                     r_m_last, n_m_last;

    logic                     accept;
    t_chan_evt                evt;
    t_class                   evt_cls;
    logic [RAW_W-1:0]         lo, hi;
    logic                     map_bad;
    logic                     div_start;
    logic [N_W-1:0]           div_dividend;
    logic                     div_done;
    logic [N_W-1:0]           div_quo;
    logic signed [RES_W-1:0]  res;
    logic signed [SAT_W-1:0]  res_ext;
    logic                     out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    rcfd_unpack #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_unpack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (s_axis_tdata),
        .i_frame_start  (s_axis_tuser),
        .i_sync_address (r_sync_address),
        .i_frame_kind   (r_frame_kind),
        .o_evt          (evt)
    );

    assign div_start    = (r_state == ST_START);
    assign div_dividend = N_W'({r_prod, 1'b0}) + N_W'(r_den);

    rcfd_div #(
        .N_W (N_W),
        .D_W (D_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  ({r_den, 1'b0}),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        evt_cls = class_of(evt.index);
        lo      = (evt_cls == CLS_KNOB) ? r_knob_low  : r_stick_low;
        hi      = (evt_cls == CLS_KNOB) ? r_knob_high : r_stick_high;
        map_bad = (lo >= hi) || (r_center_point <= lo) || (r_center_point >= hi);

        // quotient never exceeds the full scale
        if (r_lower) begin
            res = $signed({1'b0, div_quo[S_W-1:0]}) - $signed({1'b0, SCALE});
        end else begin
            res = $signed({1'b0, div_quo[S_W-1:0]});
        end
        res_ext  = SAT_W'(res);
        out_free = !r_m_valid || m_axis_tready;

        n_state   = r_state;
        n_ch      = r_ch;
        n_raw     = r_raw;
        n_cls     = r_cls;
        n_sw      = r_sw;
        n_map     = r_map;
        n_lower   = r_lower;
        n_diff    = r_diff;
        n_den     = r_den;
        n_prod    = r_prod;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        n_m_cls   = r_m_cls;
        n_m_last  = r_m_last;

        unique case (r_state)
            ST_IDLE: begin
                if (evt.valid) begin
                    n_ch    = evt.index;
                    n_raw   = evt.raw;
                    n_cls   = evt_cls;
                    n_sw    = SW_OFF;
                    n_map   = '0;
                    n_state = ST_OUT;
                    if (evt_cls == CLS_STICK || evt_cls == CLS_KNOB) begin
                        if (map_bad || evt.raw < lo) begin
                            n_map = MAP_NEG_FULL;
                        end else if (evt.raw > hi) begin
                            n_map = MAP_POS_FULL;
                        end else if (evt.raw < r_center_point) begin
                            n_lower = 1'b1;
                            n_diff  = evt.raw - lo;
                            n_den   = r_center_point - lo;
                            n_state = ST_MUL;
                        end else begin
                            n_lower = 1'b0;
                            n_diff  = evt.raw - r_center_point;
                            n_den   = hi - r_center_point;
                            n_state = ST_MUL;
                        end
                    end else if (evt_cls == CLS_SW3) begin
                        if (evt.raw == SW3_POS1_RAW) begin
                            n_sw = SW_POS1;
                        end else if (evt.raw == SW3_POS2_RAW) begin
                            n_sw = SW_POS2;
                        end
                    end else if (evt_cls == CLS_SW2) begin
                        n_sw = (evt.raw > SW2_ON_ABOVE) ? SW_POS1 : SW_OFF;
                    end
                end
            end
            ST_MUL: begin
                n_prod  = P_W'(r_diff) * P_W'(SCALE);
                n_state = ST_START;
            end
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    if (res_ext > SAT_HI) begin
                        n_map = MAP_W'(MAP_MAX);
                    end else if (res_ext < SAT_LO) begin
                        n_map = MAP_W'(MAP_MIN);
                    end else begin
                        n_map = $signed(res_ext[MAP_W-1:0]);
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the result register is free
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{OUT_PAD_W{1'b0}}, r_sw, r_map, r_raw, r_ch};
                    n_m_cls   = r_cls;
                    n_m_last  = (r_ch == CH_W'(CHANNEL_COUNT - 1));
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_address <= RST_SYNC_ADDRESS;
            r_frame_kind   <= RST_FRAME_KIND;
            r_stick_low    <= RST_STICK_LOW;
            r_stick_high   <= RST_STICK_HIGH;
            r_center_point <= RST_CENTER_POINT;
            r_knob_low     <= RST_KNOB_LOW;
            r_knob_high    <= RST_KNOB_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_ADDRESS: r_sync_address <= i_cfg_data[BYTE_W-1:0];
                CFG_FRAME_KIND:   r_frame_kind   <= i_cfg_data[BYTE_W-1:0];
                CFG_STICK_LOW:    r_stick_low    <= i_cfg_data[RAW_W-1:0];
                CFG_STICK_HIGH:   r_stick_high   <= i_cfg_data[RAW_W-1:0];
                CFG_CENTER_POINT: r_center_point <= i_cfg_data[RAW_W-1:0];
                CFG_KNOB_LOW:     r_knob_low     <= i_cfg_data[RAW_W-1:0];
                CFG_KNOB_HIGH:    r_knob_high    <= i_cfg_data[RAW_W-1:0];
                default:          r_knob_high    <= r_knob_high;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
        r_ch     <= n_ch;
        r_raw    <= n_raw;
        r_cls    <= n_cls;
        r_sw     <= n_sw;
        r_map    <= n_map;
        r_lower  <= n_lower;
        r_diff   <= n_diff;
        r_den    <= n_den;
        r_prod   <= n_prod;
        r_m_data <= n_m_data;
        r_m_cls  <= n_m_cls;
        r_m_last <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_cls;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

>>> rtl/rcfd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_div #(
    parameter int N_W = 28,
    parameter int D_W = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_done,
    output logic      [N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [N_W-1:0]   r_quo, n_quo;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_den, n_den;

    logic [D_W:0]     trial;
    logic [D_W:0]     trial_sub;
    logic             ge;

    always_comb begin
        trial     = {r_rem, r_quo[N_W-1]};
        ge        = (trial >= {1'b0, r_den});
        trial_sub = trial - {1'b0, r_den};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(N_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, keep the remainder below the divisor
            n_quo = {r_quo[N_W-2:0], ge};
            n_rem = ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> rtl/rcfd_unpack.sv
// Header check and little-endian 11-bit channel unpacking of the frame byte stream.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_unpack #(
    parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [rcfd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                        i_frame_start,
    input  wire logic [rcfd_pkg::BYTE_W-1:0] i_sync_address,
    input  wire logic [rcfd_pkg::BYTE_W-1:0] i_frame_kind,
    output rcfd_pkg::t_chan_evt              o_evt
);

    import rcfd_pkg::*;

    localparam int NC_W   = $clog2(CHANNEL_COUNT + 1);
    localparam int HELD_W = 4;
    localparam int SUM_W  = 5;
    localparam int BUF_W  = RAW_W - 1;
    localparam int ACC_W  = BUF_W + BYTE_W;

    localparam logic [1:0] POS_IDLE = 2'd0;
    localparam logic [1:0] POS_LEN  = 2'd1;
    localparam logic [1:0] POS_KIND = 2'd2;
    localparam logic [1:0] POS_DATA = 2'd3;

    logic [1:0]        r_pos, n_pos;
    logic              r_hdr_ok, n_hdr_ok;
    logic [BUF_W-1:0]  r_buf, n_buf;
    logic [HELD_W-1:0] r_held, n_held;
    logic [NC_W-1:0]   r_next, n_next;

    logic [ACC_W-1:0]  acc;
    logic [SUM_W-1:0]  held_sum;
    t_chan_evt         evt;

    always_comb begin
        acc      = ACC_W'(r_buf) | (ACC_W'(i_byte) << r_held);
        held_sum = SUM_W'(r_held) + SUM_W'(BYTE_W);

        n_pos    = r_pos;
        n_hdr_ok = r_hdr_ok;
        n_buf    = r_buf;
        n_held   = r_held;
        n_next   = r_next;
        evt      = '0;

        if (i_accept) begin
            if (i_frame_start) begin
                // restart: drop pending bits
                n_pos    = POS_LEN;
                n_hdr_ok = (i_byte == i_sync_address);
                n_buf    = '0;
                n_held   = '0;
                n_next   = '0;
            end else begin
                unique case (r_pos)
                    POS_IDLE: n_pos = r_pos;
                    POS_LEN:  n_pos = POS_KIND;
                    POS_KIND: begin
                        n_pos    = POS_DATA;
                        n_hdr_ok = r_hdr_ok && (i_byte == i_frame_kind);
                    end
                    POS_DATA: begin
                        if (r_hdr_ok && (r_next < NC_W'(CHANNEL_COUNT))) begin
                            if (held_sum < SUM_W'(RAW_W)) begin
                                n_buf  = acc[BUF_W-1:0];
                                n_held = held_sum[HELD_W-1:0];
                            end else begin
                                evt.valid = 1'b1;
                                evt.index = CH_W'(r_next);
                                evt.raw   = acc[RAW_W-1:0];
                                n_buf     = BUF_W'(acc[ACC_W-1:RAW_W]);
                                n_held    = HELD_W'(held_sum - SUM_W'(RAW_W));
                                n_next    = r_next + NC_W'(1);
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_IDLE;
            r_hdr_ok <= 1'b0;
            r_buf    <= '0;
            r_held   <= '0;
            r_next   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_hdr_ok <= n_hdr_ok;
            r_buf    <= n_buf;
            r_held   <= n_held;
            r_next   <= n_next;
        end
    end

    assign o_evt = evt;

endmodule

`default_nettype wire

>>> rtl/rcfd_check.sv
// Port-level checker for the RC channel frame decoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_check #(
    parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [rcfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [rcfd_pkg::CLS_W-1:0]       m_axis_tuser,
    input wire logic                             m_axis_tlast
);

    import rcfd_pkg::*;

    logic [CH_W-1:0]  out_idx;
    logic [MAP_W-1:0] out_map;
    logic [SW_W-1:0]  out_sw;

    assign out_idx = m_axis_tdata[CH_W-1:0];
    assign out_map = m_axis_tdata[OUT_MAP_LSB +: MAP_W];
    assign out_sw  = m_axis_tdata[OUT_SW_LSB +: SW_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (out_idx == CH_W'(CHANNEL_COUNT - 1))))
        else $error("tlast does not match the final channel");

    a_map_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != CLS_STICK && m_axis_tuser != CLS_KNOB
            |-> out_map == '0)
        else $error("mapped value set on a channel without a map");

    a_switch_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_sw == SW_OFF || out_sw == SW_POS1
            || (out_sw == SW_POS2 && m_axis_tuser == CLS_SW3))
            && (out_sw == SW_OFF || m_axis_tuser == CLS_SW3 || m_axis_tuser == CLS_SW2))
        else $error("switch position inconsistent with channel class");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without the input side being held");

endmodule

bind rc_channel_frame_decoder rcfd_check #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
) u_rcfd_check (.*);

`default_nettype wire

>>> tb/tb_rc_channel_frame_decoder.sv
// Self-checking testbench of the RC channel frame decoder: byte stream in, channel results out.
`timescale 1ns / 1ps
`default_nettype none

module tb_rc_channel_frame_decoder;

    import rcfd_pkg::*;

    localparam int CHANNELS     = CHANNEL_COUNT_DEF;
    localparam int FRAC_BITS    = FRACTION_BITS_DEF;
    localparam int FULL_SCALE   = MAP_SPAN * (1 << FRAC_BITS);
    localparam int DRAIN_CYCLES = FRAC_BITS + 17 + 15;
    localparam int PHASES       = 7;
    localparam int PHASE_BYTES  = 85;
    localparam int PAYLOAD_BITS = CHANNELS * RAW_W;
    localparam logic [RAW_W-1:0] RAW_TOP = 11'h7FF;
    // Index beyond the register file; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0]         ch;
        logic [RAW_W-1:0]        raw;
        t_class                  cls;
        logic signed [MAP_W-1:0] pos;
        logic [SW_W-1:0]         sw;
        logic                    last;
    } t_chan_result;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              first;
        bit                typed;
        t_chan_result      res;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;   // byte_value
    logic                   s_axis_tuser;   // frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // channel_index, raw_value, mapped_value, switch_state, zero padding
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [CLS_W-1:0]       m_axis_tuser;   // channel_class
    logic                   m_axis_tlast;   // last_channel

    rc_channel_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Decoder copy: configuration and frame state
    logic [BYTE_W-1:0] cfg_sync, cfg_kind;
    logic [RAW_W-1:0]  cfg_stick_lo, cfg_stick_hi, cfg_centre, cfg_knob_lo, cfg_knob_hi;
    logic [4:0]        byte_pos;
    logic              header_ok;
    logic [15:0]       bit_store;
    int unsigned       bits_held;
    int unsigned       next_chan;

    t_chan_result pending_channels[$];
    t_stim_row    opening_rows[$];
    int unsigned  errors;
    int unsigned  results_seen;
    int unsigned  bytes_sent;
    int unsigned  settings_used;
    bit           src_calm;
    bit           sink_calm;

    function automatic longint half_up(input longint num, input longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic signed [MAP_W-1:0] position_of(input int unsigned v,
            input int unsigned lo, input int unsigned hi, input int unsigned c);
        longint s;
        longint m;
        s = longint'(FULL_SCALE);
        if (lo >= hi || c <= lo || c >= hi)
            m = -s;
        else if (v < c)
            m = (v < lo) ? -s : -s + half_up(s * longint'(v - lo), longint'(c - lo));
        else if (v > hi)
            m = s;
        else
            m = half_up(s * longint'(v - c), longint'(hi - c));
        if (m > MAP_MAX) m = MAP_MAX;
        if (m < MAP_MIN) m = MAP_MIN;
        return m[MAP_W-1:0];
    endfunction

    function automatic bit decode_byte(input logic [BYTE_W-1:0] value, input logic first,
            output t_chan_result res);
        logic [31:0] acc;
        logic [4:0]  pos;
        int unsigned held;
        int unsigned chan;
        res = '0;
        if (first) begin
            byte_pos  = 5'd1;
            header_ok = (value == cfg_sync);
            bit_store = '0;
            bits_held = 0;
            next_chan = 0;
            return 1'b0;
        end
        if (byte_pos == 5'd0)
            return 1'b0;
        pos = byte_pos;
        if (byte_pos < 5'd31)
            byte_pos = byte_pos + 5'd1;
        if (pos == 5'd1)
            return 1'b0;
        if (pos == 5'd2) begin
            header_ok = header_ok && (value == cfg_kind);
            return 1'b0;
        end
        if (!header_ok || next_chan >= CHANNELS)
            return 1'b0;
        acc  = {21'd0, bit_store[RAW_W-1:0]} | (32'(value) << bits_held);
        held = bits_held + 8;
        if (held < RAW_W) begin
            bit_store = acc[15:0];
            bits_held = held;
            return 1'b0;
        end
        bit_store = acc[RAW_W +: 16];
        bits_held = held - RAW_W;
        chan      = next_chan;
        next_chan = next_chan + 1;
        res.ch    = chan[CH_W-1:0];
        res.raw   = acc[RAW_W-1:0];
        res.last  = (chan == CHANNELS - 1);
        res.cls   = CLS_PLAIN;
        res.pos   = '0;
        res.sw    = SW_OFF;
        if (chan <= 3) begin
            res.cls = CLS_STICK;
            res.pos = position_of(32'(res.raw), 32'(cfg_stick_lo), 32'(cfg_stick_hi),
                                  32'(cfg_centre));
        end else if (chan == 10 || chan == 11) begin
            res.cls = CLS_KNOB;
            res.pos = position_of(32'(res.raw), 32'(cfg_knob_lo), 32'(cfg_knob_hi),
                                  32'(cfg_centre));
        end else if (chan >= 5 && chan <= 8) begin
            res.cls = CLS_SW3;
            if (res.raw == SW3_POS1_RAW)
                res.sw = SW_POS1;
            else if (res.raw == SW3_POS2_RAW)
                res.sw = SW_POS2;
        end else if (chan == 4 || chan == 9) begin
            res.cls = CLS_SW2;
            res.sw  = (res.raw > SW2_ON_ABOVE) ? SW_POS1 : SW_OFF;
        end
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [BYTE_W-1:0] value, input logic first);
        t_stim_row row;
        row.value = value;
        row.first = first;
        row.typed = 1'b0;
        row.res   = '0;
        opening_rows.push_back(row);
    endfunction

    // Payload byte of all ones that completes a channel at raw full scale
    function automatic void add_typed(input int unsigned ch, input t_class cls,
            input int pos, input logic [SW_W-1:0] sw);
        t_stim_row row;
        row.value    = 8'hFF;
        row.first    = 1'b0;
        row.typed    = 1'b1;
        row.res.ch   = ch[CH_W-1:0];
        row.res.raw  = RAW_TOP;
        row.res.cls  = cls;
        row.res.pos  = pos[MAP_W-1:0];
        row.res.sw   = sw;
        row.res.last = (ch == CHANNELS - 1);
        opening_rows.push_back(row);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic first,
            input bit typed, input t_chan_result typed_res);
        int unsigned  gap;
        t_chan_result res;
        bit           made;
        gap = src_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        made = decode_byte(value, first, res);
        if (typed)
            pending_channels.push_back(typed_res);
        else if (made)
            pending_channels.push_back(res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SYNC_ADDRESS: cfg_sync     = data[BYTE_W-1:0];
            CFG_FRAME_KIND:   cfg_kind     = data[BYTE_W-1:0];
            CFG_STICK_LOW:    cfg_stick_lo = data[RAW_W-1:0];
            CFG_STICK_HIGH:   cfg_stick_hi = data[RAW_W-1:0];
            CFG_CENTER_POINT: cfg_centre   = data[RAW_W-1:0];
            CFG_KNOB_LOW:     cfg_knob_lo  = data[RAW_W-1:0];
            CFG_KNOB_HIGH:    cfg_knob_hi  = data[RAW_W-1:0];
            default: ;
        endcase
    endtask

    // Hold off until every result is back and any divider run has finished
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_channels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [RAW_W-1:0] slo, input logic [RAW_W-1:0] shi,
            input logic [RAW_W-1:0] c, input logic [RAW_W-1:0] klo, input logic [RAW_W-1:0] khi);
        write_reg(CFG_STICK_LOW, slo);
        write_reg(CFG_STICK_HIGH, shi);
        write_reg(CFG_CENTER_POINT, c);
        write_reg(CFG_KNOB_LOW, klo);
        write_reg(CFG_KNOB_HIGH, khi);
    endtask

    task automatic random_setting();
        logic [RAW_W-1:0] a, b, c, t;
        a = RAW_W'($urandom_range(0, 2047));
        b = RAW_W'($urandom_range(0, 2047));
        c = RAW_W'($urandom_range(0, 2047));
        // Mostly ordered limits; now and then leave them as drawn
        if ($urandom_range(0, 4) != 0) begin
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
        end
        write_reg(CFG_SYNC_ADDRESS, CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(CFG_FRAME_KIND, CFG_DATA_W'($urandom_range(0, 2047)));
        write_limits(a, c, b, RAW_W'($urandom_range(0, 32'(b))),
                     RAW_W'($urandom_range(32'(b), 2047)));
    endtask

    task automatic apply_setting(input int phase);
        case (phase)
            1: begin
                write_reg(CFG_SYNC_ADDRESS, 11'h000);
                write_reg(CFG_FRAME_KIND, 11'h0FF);
                write_limits(11'd0, 11'd2047, 11'd1024, 11'd1, 11'd2046);
            end
            2: begin
                // Reversed stick limits and a centre on the knob floor: both maps invalid
                write_reg(CFG_SYNC_ADDRESS, 11'h7FF);
                write_reg(CFG_FRAME_KIND, 11'h700);
                write_limits(11'd2047, 11'd0, 11'd0, 11'd0, 11'd2047);
            end
            3: begin
                write_reg(CFG_SYNC_ADDRESS, 11'h0C8);
                write_reg(CFG_FRAME_KIND, 11'h016);
                write_limits(11'd100, 11'd1000, 11'd1000, 11'd500, 11'd1500);
            end
            4: begin
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));
                random_setting();
            end
            5: random_setting();
            6: begin
                write_reg(CFG_SYNC_ADDRESS, CFG_DATA_W'(RST_SYNC_ADDRESS));
                write_reg(CFG_FRAME_KIND, CFG_DATA_W'(RST_FRAME_KIND));
                write_limits(RST_STICK_LOW, RST_STICK_HIGH, RST_CENTER_POINT, RST_KNOB_LOW,
                             RST_KNOB_HIGH);
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        logic [RAW_W-1:0] v;
        case ($urandom_range(0, 9))
            1: v = '0;
            2: v = RAW_TOP;
            3: v = SW3_POS1_RAW;
            4: v = SW3_POS2_RAW;
            5: v = SW2_ON_ABOVE + RAW_W'($urandom_range(0, 1));
            6: v = cfg_centre + RAW_W'($urandom_range(0, 2)) - 1'b1;
            7: v = ($urandom_range(0, 1) ? cfg_stick_lo : cfg_stick_hi)
                   + RAW_W'($urandom_range(0, 2)) - 1'b1;
            8: v = ($urandom_range(0, 1) ? cfg_knob_lo : cfg_knob_hi)
                   + RAW_W'($urandom_range(0, 2)) - 1'b1;
            default: v = RAW_W'($urandom_range(0, 2047));
        endcase
        return v;
    endfunction

    task automatic emit_frame();
        logic [PAYLOAD_BITS-1:0] payload;
        logic [BYTE_W-1:0]       head0, head2;
        int unsigned             shape, len, extra;
        t_chan_result            none;
        none     = '0;
        shape    = $urandom_range(0, 19);
        src_calm = ($urandom_range(0, 3) == 0);
        if (shape == 18) begin
            // Loose bytes, an odd frame start among them
            repeat ($urandom_range(1, 4))
                send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0,
                          none);
            return;
        end
        for (int k = 0; k < CHANNELS; k++)
            payload[k*RAW_W +: RAW_W] = pick_raw();
        head0 = cfg_sync;
        head2 = cfg_kind;
        if (shape == 14) head0 = cfg_sync ^ BYTE_W'($urandom_range(1, 255));
        if (shape == 15) head2 = cfg_kind ^ BYTE_W'($urandom_range(1, 255));
        len   = (shape == 16 || shape == 17) ? $urandom_range(3, 24) : 25;
        extra = (shape == 19) ? $urandom_range(7, 12) : $urandom_range(0, 1);
        send_byte(head0, 1'b1, 1'b0, none);
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, none);
        send_byte(head2, 1'b0, 1'b0, none);
        for (int j = 0; j < int'(len) - 3; j++)
            send_byte(payload[j*8 +: 8], 1'b0, 1'b0, none);
        repeat (extra)
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, none);
    endtask

    task automatic check_result();
        t_chan_result want;
        if (pending_channels.size() == 0) begin
            $error("result with nothing expected: channel_index %0d raw_value %0d",
                   m_axis_tdata[CH_W-1:0], m_axis_tdata[OUT_RAW_LSB +: RAW_W]);
            errors++;
            return;
        end
        want = pending_channels.pop_front();
        results_seen++;
        if (m_axis_tdata[CH_W-1:0] !== want.ch) begin
            $error("channel_index: expected %0d, got %0d", want.ch, m_axis_tdata[CH_W-1:0]);
            errors++;
        end
        if (m_axis_tdata[OUT_RAW_LSB +: RAW_W] !== want.raw) begin
            $error("raw_value: expected %0d, got %0d", want.raw,
                   m_axis_tdata[OUT_RAW_LSB +: RAW_W]);
            errors++;
        end
        if (m_axis_tuser !== want.cls) begin
            $error("channel_class: expected %0d, got %0d", want.cls, m_axis_tuser);
            errors++;
        end
        if (m_axis_tdata[OUT_MAP_LSB +: MAP_W] !== want.pos) begin
            $error("mapped_value: expected %0d, got %0d", want.pos,
                   $signed(m_axis_tdata[OUT_MAP_LSB +: MAP_W]));
            errors++;
        end
        if (m_axis_tdata[OUT_SW_LSB +: SW_W] !== want.sw) begin
            $error("switch_state: expected %0d, got %0d", want.sw,
                   m_axis_tdata[OUT_SW_LSB +: SW_W]);
            errors++;
        end
        if (m_axis_tlast !== want.last) begin
            $error("last_channel: expected %0d, got %0d", want.last, m_axis_tlast);
            errors++;
        end
        if (OUT_PAD_W > 0 && m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
            $error("padding: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
            errors++;
        end
    endtask

    initial begin : result_sink
        int unsigned gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (results_seen % 32 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            gap = sink_calm ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_result();
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        errors        = 0;
        results_seen  = 0;
        bytes_sent    = 0;
        settings_used = 1;
        src_calm      = 1'b0;
        sink_calm     = 1'b0;
        cfg_sync      = RST_SYNC_ADDRESS;
        cfg_kind      = RST_FRAME_KIND;
        cfg_stick_lo  = RST_STICK_LOW;
        cfg_stick_hi  = RST_STICK_HIGH;
        cfg_centre    = RST_CENTER_POINT;
        cfg_knob_lo   = RST_KNOB_LOW;
        cfg_knob_hi   = RST_KNOB_HIGH;
        byte_pos      = '0;
        header_ok     = 1'b0;
        bit_store     = '0;
        bits_held     = 0;
        next_chan     = 0;

        // Byte before any frame start, then a frame with a wrong sync byte
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b1);
        add_row(8'h18, 1'b0);
        add_row(RST_FRAME_KIND, 1'b0);
        // Good frame, payload all ones: every channel at raw full scale
        add_row(RST_SYNC_ADDRESS, 1'b1);
        add_row(8'h18, 1'b0);
        add_row(RST_FRAME_KIND, 1'b0);
        add_row(8'hFF, 1'b0);
        add_typed(0, CLS_STICK, FULL_SCALE, SW_OFF);
        add_typed(1, CLS_STICK, FULL_SCALE, SW_OFF);
        add_row(8'hFF, 1'b0);
        add_typed(2, CLS_STICK, FULL_SCALE, SW_OFF);
        add_typed(3, CLS_STICK, FULL_SCALE, SW_OFF);
        add_typed(4, CLS_SW2, 0, SW_POS1);
        add_row(8'hFF, 1'b0);
        add_typed(5, CLS_SW3, 0, SW_OFF);
        add_typed(6, CLS_SW3, 0, SW_OFF);
        add_typed(7, CLS_SW3, 0, SW_OFF);
        add_row(8'hFF, 1'b0);
        add_typed(8, CLS_SW3, 0, SW_OFF);
        add_typed(9, CLS_SW2, 0, SW_POS1);
        add_row(8'hFF, 1'b0);
        add_typed(10, CLS_KNOB, FULL_SCALE, SW_OFF);
        add_typed(11, CLS_KNOB, FULL_SCALE, SW_OFF);
        add_typed(12, CLS_PLAIN, 0, SW_OFF);
        add_row(8'hFF, 1'b0);
        add_typed(13, CLS_PLAIN, 0, SW_OFF);
        add_typed(14, CLS_PLAIN, 0, SW_OFF);
        add_typed(15, CLS_PLAIN, 0, SW_OFF);
        add_row(8'hFF, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[i])
            send_byte(opening_rows[i].value, opening_rows[i].first, opening_rows[i].typed,
                      opening_rows[i].res);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            int unsigned start_count;
            if (phase != 0)
                apply_setting(phase);
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES)
                emit_frame();
            settle();
        end

        $display("covered %0d bytes and %0d channel results over %0d register settings",
                 bytes_sent, results_seen, settings_used);
        $display("frames: good, bad sync, bad kind, cut short, overlong, loose bytes");
        if (errors == 0) begin
            $display("tb_rc_channel_frame_decoder: done, clean");
        end else begin
            $display("tb_rc_channel_frame_decoder: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_rc_channel_frame_decoder: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/rcfd_pkg.sv
rtl/rcfd_div.sv
rtl/rcfd_unpack.sv
rtl/rc_channel_frame_decoder.sv
rtl/rcfd_check.sv
tb/tb_rc_channel_frame_decoder.sv
